// ===== hdl/gcwf_pkg.sv =====
`default_nettype none
package gcwf_pkg;

  typedef enum logic [3:0] {
    WK_HEADER   = 4'd0,
    WK_PARAM    = 4'd1,
    WK_PVERT    = 4'd2,
    WK_PEND     = 4'd3,
    WK_IMAGE    = 4'd4,
    WK_SETTING  = 4'd5,
    WK_NOP      = 4'd6,
    WK_INVALID  = 4'd7,
    WK_CONTROL  = 4'd8
  } word_kind_e;

  typedef enum logic [3:0] {
    PK_NONE     = 4'd0,
    PK_POLYGON  = 4'd1,
    PK_LINE     = 4'd2,
    PK_POLYLINE = 4'd3,
    PK_RECT     = 4'd4,
    PK_FILL     = 4'd5,
    PK_COPY     = 4'd6,
    PK_TOVRAM   = 4'd7,
    PK_FROMVRAM = 4'd8
  } packet_type_e;

  typedef enum logic [1:0] {
    MODE_CMD    = 2'd0,
    MODE_PARAMS = 2'd1,
    MODE_POLY   = 2'd2,
    MODE_IMAGE  = 2'd3
  } rx_mode_e;

  localparam logic [31:0] TERM_PATTERN = 32'h5000_5000;

  // command port opcodes
  localparam logic [7:0] OP_NOP_00   = 8'h00;
  localparam logic [7:0] OP_NOP_01   = 8'h01;
  localparam logic [7:0] OP_FILL     = 8'h02;
  localparam logic [7:0] OP_NOP_03   = 8'h03;
  localparam logic [7:0] OP_NOP_04   = 8'h04;
  localparam logic [7:0] OP_NOP_1E   = 8'h1e;
  localparam logic [7:0] OP_IRQ      = 8'h1f;
  localparam logic [7:0] OP_COPY     = 8'h80;
  localparam logic [7:0] OP_TOVRAM   = 8'ha0;
  localparam logic [7:0] OP_FROMVRAM = 8'hc0;
  localparam logic [7:0] OP_NOP_E0   = 8'he0;
  localparam logic [7:0] OP_DRAWMODE = 8'he1;
  localparam logic [7:0] OP_TEXWIN   = 8'he2;
  localparam logic [7:0] OP_AREA_TL  = 8'he3;
  localparam logic [7:0] OP_AREA_BR  = 8'he4;
  localparam logic [7:0] OP_OFFSET   = 8'he5;
  localparam logic [7:0] OP_MASK     = 8'he6;
  localparam logic [7:0] OP_NOP_E7   = 8'he7;
  localparam logic [7:0] OP_NOP_EF   = 8'hef;

  // primitive classes in bits 31..29
  localparam logic [2:0] PRIM_POLY = 3'd1;
  localparam logic [2:0] PRIM_LINE = 3'd2;
  localparam logic [2:0] PRIM_RECT = 3'd3;

  // control port opcodes
  localparam logic [7:0] CTL_RESET   = 8'h00;
  localparam logic [7:0] CTL_CLRBUF  = 8'h01;
  localparam logic [7:0] CTL_IRQ_ACK = 8'h02;
  localparam logic [7:0] CTL_INFO    = 8'h10;

  // info readback selectors
  localparam logic [2:0] INFO_TEXWIN  = 3'd2;
  localparam logic [2:0] INFO_AREA_TL = 3'd3;
  localparam logic [2:0] INFO_AREA_BR = 3'd4;
  localparam logic [2:0] INFO_OFFSET  = 3'd5;

  typedef struct packed {
    logic        port;
    logic [31:0] data_word;
  } in_word_t;

  typedef struct packed {
    word_kind_e   word_kind;
    packet_type_e packet_type;
    logic         last;
    logic [3:0]   params_left;
    logic [19:0]  pixels_left;
    logic [31:0]  read_data;
    logic         irq;
    logic         irq_raise;
    logic [8:0]   draw_mode;
    logic [1:0]   mask_bits;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/gpu_command_word_framer.sv =====
// Command word framer for a display processor with a command port and a
// control port.
// Input channel: in_valid_i / in_stall_o with in_data_i (port select and
// the 32-bit word). A word is taken at a clock edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i with out_data_o,
// one result word for every input word, in order.
// Path: an accepted word sits in the input register while it is decoded
// against the kept framing state and environment; its result is written
// to the output register when the word advances. Throughput: one word per
// cycle when the receiver does not stall, set by the single decode pass
// between the input and output registers.
// When the receiver stalls, the output register holds its word; the input
// register can still take one more word, after which in_stall_o rises until
// the output drains.
// Reset clears both valid flags, the framing state (command mode, no open
// packet), the drawing environment, the interrupt flag and the read latch.
`default_nettype none
module gpu_command_word_framer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire gcwf_pkg::in_word_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output gcwf_pkg::out_word_t     out_data_o
);
  import gcwf_pkg::*;

  // pipeline registers
  logic      in_valid_q;
  in_word_t  in_q;
  logic      out_valid_q;
  out_word_t out_q;
  out_word_t out_d;

  logic out_ready;
  logic in_take;
  logic advance;

  // framing state
  rx_mode_e     mode_q, mode_d;
  logic [3:0]   params_q, params_d;
  packet_type_e pk_q, pk_d;
  logic [19:0]  pixels_q, pixels_d;

  // environment
  logic [19:0] texwin_q, texwin_d;
  logic [18:0] area_tl_q, area_tl_d;
  logic [18:0] area_br_q, area_br_d;
  logic [21:0] offset_q, offset_d;
  logic [8:0]  mode_bits_q, mode_bits_d;
  logic [1:0]  mask_q, mask_d;
  logic        irq_q, irq_d;
  logic [31:0] latch_q, latch_d;

  // decode helpers
  logic [31:0] w;
  logic [7:0]  op;
  logic        tex, shade, bit27;
  logic [3:0]  verts, mult, poly_n, rect_n, line_n;
  logic [3:0]  params_dec;
  logic [10:0] img_w;
  logic [9:0]  img_h;
  logic [20:0] img_px;

  word_kind_e   kind;
  packet_type_e pk_out;
  logic         last;
  logic         raise;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  assign w     = in_q.data_word;
  assign op    = w[31:24];
  assign tex   = w[26];
  assign shade = w[28];
  assign bit27 = w[27];

  assign verts  = 4'd3 + 4'(bit27);
  assign mult   = 4'd1 + 4'(tex) + 4'(shade);
  assign poly_n = 4'(verts * mult) - 4'(shade);
  assign rect_n = 4'd1 + 4'(w[28:27] == 2'd0) + 4'(tex);
  assign line_n = shade ? 4'd3 : 4'd2;

  assign params_dec = (params_q != 4'd0) ? params_q - 4'd1 : 4'd0;

  // width and height wrap to 1..1024 and 1..512
  assign img_w  = {1'b0, w[9:0] - 10'd1} + 11'd1;
  assign img_h  = {1'b0, w[24:16] - 9'd1} + 10'd1;
  assign img_px = 21'(img_w * img_h);

  always_comb begin
    mode_d      = mode_q;
    params_d    = params_q;
    pk_d        = pk_q;
    pixels_d    = pixels_q;
    texwin_d    = texwin_q;
    area_tl_d   = area_tl_q;
    area_br_d   = area_br_q;
    offset_d    = offset_q;
    mode_bits_d = mode_bits_q;
    mask_d      = mask_q;
    irq_d       = irq_q;
    latch_d     = latch_q;
    kind        = WK_NOP;
    pk_out      = PK_NONE;
    last        = 1'b0;
    raise       = 1'b0;

    if (in_q.port) begin
      kind = WK_CONTROL;
      unique case (op)
        CTL_RESET: begin
          texwin_d    = '0;
          area_tl_d   = '0;
          area_br_d   = '0;
          offset_d    = '0;
          mode_bits_d = '0;
          mask_d      = '0;
          irq_d       = 1'b0;
          mode_d      = MODE_CMD;
          params_d    = '0;
          pk_d        = PK_NONE;
          pixels_d    = '0;
        end
        CTL_CLRBUF: begin
          mode_d   = MODE_CMD;
          params_d = '0;
          pk_d     = PK_NONE;
          pixels_d = '0;
        end
        CTL_IRQ_ACK: irq_d = 1'b0;
        CTL_INFO: begin
          unique case (w[2:0])
            INFO_TEXWIN:  latch_d = {12'd0, texwin_q};
            INFO_AREA_TL: latch_d = {13'd0, area_tl_q};
            INFO_AREA_BR: latch_d = {13'd0, area_br_q};
            INFO_OFFSET:  latch_d = {10'd0, offset_q};
            default: ;
          endcase
        end
        default: ;
      endcase
      pk_out = pk_d;
    end else begin
      unique case (mode_q)
        MODE_PARAMS: begin
          kind     = WK_PARAM;
          pk_out   = pk_q;
          params_d = params_dec;
          if (params_dec == 4'd0) begin
            if (pk_q == PK_TOVRAM) begin
              pixels_d = img_px[19:0];
              mode_d   = MODE_IMAGE;
            end else begin
              last     = 1'b1;
              mode_d   = MODE_CMD;
              pk_d     = PK_NONE;
              pixels_d = '0;
            end
          end
        end
        MODE_POLY: begin
          pk_out = PK_POLYLINE;
          if ((w & TERM_PATTERN) == TERM_PATTERN) begin
            kind     = WK_PEND;
            last     = 1'b1;
            mode_d   = MODE_CMD;
            params_d = '0;
            pk_d     = PK_NONE;
            pixels_d = '0;
          end else begin
            kind = WK_PVERT;
          end
        end
        MODE_IMAGE: begin
          kind     = WK_IMAGE;
          pk_out   = PK_TOVRAM;
          // two pixels a word, one if only one is left
          pixels_d = (pixels_q >= 20'd2) ? pixels_q - 20'd2 : 20'd0;
          if (pixels_d == 20'd0) begin
            last     = 1'b1;
            mode_d   = MODE_CMD;
            params_d = '0;
            pk_d     = PK_NONE;
          end
        end
        MODE_CMD: begin
          unique case (op)
            OP_DRAWMODE: begin
              kind        = WK_SETTING;
              mode_bits_d = {w[13], w[12], w[11], w[5:0]};
            end
            OP_TEXWIN: begin
              kind     = WK_SETTING;
              texwin_d = w[19:0];
            end
            OP_AREA_TL: begin
              kind      = WK_SETTING;
              area_tl_d = w[18:0];
            end
            OP_AREA_BR: begin
              kind      = WK_SETTING;
              area_br_d = w[18:0];
            end
            OP_OFFSET: begin
              kind     = WK_SETTING;
              offset_d = w[21:0];
            end
            OP_MASK: begin
              kind   = WK_SETTING;
              mask_d = w[1:0];
            end
            OP_IRQ: begin
              kind = WK_SETTING;
              if (!irq_q) begin
                irq_d = 1'b1;
                raise = 1'b1;
              end
            end
            OP_FILL: begin
              kind     = WK_HEADER;
              pk_out   = PK_FILL;
              pk_d     = PK_FILL;
              params_d = 4'd2;
              mode_d   = MODE_PARAMS;
            end
            OP_COPY: begin
              kind     = WK_HEADER;
              pk_out   = PK_COPY;
              pk_d     = PK_COPY;
              params_d = 4'd3;
              mode_d   = MODE_PARAMS;
            end
            OP_TOVRAM: begin
              kind     = WK_HEADER;
              pk_out   = PK_TOVRAM;
              pk_d     = PK_TOVRAM;
              params_d = 4'd2;
              mode_d   = MODE_PARAMS;
            end
            OP_FROMVRAM: begin
              kind     = WK_HEADER;
              pk_out   = PK_FROMVRAM;
              pk_d     = PK_FROMVRAM;
              params_d = 4'd2;
              mode_d   = MODE_PARAMS;
            end
            OP_NOP_00, OP_NOP_01, OP_NOP_03, OP_NOP_04,
            OP_NOP_1E, OP_NOP_E0, OP_NOP_E7, OP_NOP_EF: begin
              kind = WK_NOP;
            end
            default: begin
              kind = WK_HEADER;
              unique case (w[31:29])
                PRIM_POLY: begin
                  pk_out   = PK_POLYGON;
                  pk_d     = PK_POLYGON;
                  params_d = poly_n;
                  mode_d   = MODE_PARAMS;
                end
                PRIM_LINE: begin
                  if (bit27) begin
                    pk_out   = PK_POLYLINE;
                    pk_d     = PK_POLYLINE;
                    params_d = '0;
                    mode_d   = MODE_POLY;
                  end else begin
                    pk_out   = PK_LINE;
                    pk_d     = PK_LINE;
                    params_d = line_n;
                    mode_d   = MODE_PARAMS;
                  end
                end
                PRIM_RECT: begin
                  pk_out   = PK_RECT;
                  pk_d     = PK_RECT;
                  params_d = rect_n;
                  mode_d   = MODE_PARAMS;
                end
                default: kind = WK_INVALID;
              endcase
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d.word_kind   = kind;
    out_d.packet_type = pk_out;
    out_d.last        = last;
    out_d.params_left = params_d;
    out_d.pixels_left = pixels_d;
    out_d.read_data   = latch_d;
    out_d.irq         = irq_d;
    out_d.irq_raise   = raise;
    out_d.draw_mode   = mode_bits_d;
    out_d.mask_bits   = mask_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CMD;
      params_q    <= '0;
      pk_q        <= PK_NONE;
      pixels_q    <= '0;
      texwin_q    <= '0;
      area_tl_q   <= '0;
      area_br_q   <= '0;
      offset_q    <= '0;
      mode_bits_q <= '0;
      mask_q      <= '0;
      irq_q       <= 1'b0;
      latch_q     <= '0;
    end else if (advance) begin
      mode_q      <= mode_d;
      params_q    <= params_d;
      pk_q        <= pk_d;
      pixels_q    <= pixels_d;
      texwin_q    <= texwin_d;
      area_tl_q   <= area_tl_d;
      area_br_q   <= area_br_d;
      offset_q    <= offset_d;
      mode_bits_q <= mode_bits_d;
      mask_q      <= mask_d;
      irq_q       <= irq_d;
      latch_q     <= latch_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_cmd_mode_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_CMD |-> pk_q == PK_NONE && params_q == 4'd0 && pixels_q == 20'd0)
    else $error("command mode with open packet state");

  a_params_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_PARAMS |-> params_q != 4'd0 && pk_q != PK_NONE)
    else $error("parameter mode with no parameter pending");

  a_image_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IMAGE |-> pk_q == PK_TOVRAM && pixels_q != 20'd0)
    else $error("image mode without pixels pending");

  a_last_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last |-> out_q.params_left == 4'd0 && out_q.pixels_left == 20'd0)
    else $error("packet end with counts left");

  a_raise_sets_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && raise |=> irq_q && !$past(irq_q))
    else $error("interrupt raise without flag transition");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import gcwf_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_data = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_word_t out_data_o;

  gpu_command_word_framer dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // framing state and drawing environment as the block should hold them
  rx_mode_e     rx_mode = MODE_CMD;
  logic [3:0]   params_due = '0;
  packet_type_e open_pkt = PK_NONE;
  logic [19:0]  pixels_due = '0;
  logic [19:0]  env_texwin = '0;
  logic [18:0]  env_area_tl = '0;
  logic [18:0]  env_area_br = '0;
  logic [21:0]  env_offset = '0;
  logic [8:0]   env_draw = '0;
  logic [1:0]   env_mask = '0;
  logic         irq_flag = 1'b0;
  logic [31:0]  read_latch = '0;

  out_word_t framed_q[$];

  logic idle_en = 1'b1;
  int   hold_req = 0;
  int   hold_cnt = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   n_errors = 0;
  int   n_sent = 0;
  int   n_ctl = 0;
  int   n_checked = 0;
  int   n_closed = 0;
  int   n_image = 0;

  function automatic void clear_framing();
    rx_mode    = MODE_CMD;
    params_due = '0;
    open_pkt   = PK_NONE;
    pixels_due = '0;
  endfunction

  function automatic void start_packet(input packet_type_e pk, input logic [3:0] n);
    open_pkt   = pk;
    params_due = n;
    rx_mode    = MODE_PARAMS;
  endfunction

  function automatic out_word_t frame_word(input in_word_t iw);
    out_word_t   res;
    logic [31:0] w;
    logic        tex, shade, b27;
    int          nv;
    logic [10:0] wid;
    logic [9:0]  hgt;
    w     = iw.data_word;
    tex   = w[26];
    b27   = w[27];
    shade = w[28];
    res   = '0;
    res.word_kind   = WK_NOP;
    res.packet_type = PK_NONE;
    if (iw.port) begin
      res.word_kind = WK_CONTROL;
      case (w[31:24])
        CTL_RESET: begin
          env_texwin  = '0;
          env_area_tl = '0;
          env_area_br = '0;
          env_offset  = '0;
          env_draw    = '0;
          env_mask    = '0;
          irq_flag    = 1'b0;
          clear_framing();
        end
        CTL_CLRBUF:  clear_framing();
        CTL_IRQ_ACK: irq_flag = 1'b0;
        CTL_INFO: begin
          case (w[2:0])
            INFO_TEXWIN:  read_latch = {12'd0, env_texwin};
            INFO_AREA_TL: read_latch = {13'd0, env_area_tl};
            INFO_AREA_BR: read_latch = {13'd0, env_area_br};
            INFO_OFFSET:  read_latch = {10'd0, env_offset};
            default: ;
          endcase
        end
        default: ;
      endcase
      res.packet_type = open_pkt;
    end else if (rx_mode == MODE_PARAMS) begin
      res.word_kind   = WK_PARAM;
      res.packet_type = open_pkt;
      if (params_due != 4'd0) params_due = params_due - 4'd1;
      if (params_due == 4'd0) begin
        if (open_pkt == PK_TOVRAM) begin
          // size word: zero width or height wraps to the maximum
          wid        = {1'b0, w[9:0] - 10'd1} + 11'd1;
          hgt        = {1'b0, w[24:16] - 9'd1} + 10'd1;
          pixels_due = wid * hgt;
          rx_mode    = MODE_IMAGE;
        end else begin
          res.last = 1'b1;
          clear_framing();
        end
      end
    end else if (rx_mode == MODE_POLY) begin
      res.packet_type = PK_POLYLINE;
      if ((w & TERM_PATTERN) == TERM_PATTERN) begin
        res.word_kind = WK_PEND;
        res.last      = 1'b1;
        clear_framing();
      end else begin
        res.word_kind = WK_PVERT;
      end
    end else if (rx_mode == MODE_IMAGE) begin
      res.word_kind   = WK_IMAGE;
      res.packet_type = PK_TOVRAM;
      // two pixels per word, one when only one is left
      if (pixels_due >= 20'd2) pixels_due = pixels_due - 20'd2;
      else pixels_due = '0;
      if (pixels_due == 20'd0) begin
        res.last = 1'b1;
        clear_framing();
      end
    end else begin
      case (w[31:24])
        OP_DRAWMODE: begin
          res.word_kind = WK_SETTING;
          env_draw      = {w[13], w[12], w[11], w[5:0]};
        end
        OP_TEXWIN:  begin res.word_kind = WK_SETTING; env_texwin  = w[19:0]; end
        OP_AREA_TL: begin res.word_kind = WK_SETTING; env_area_tl = w[18:0]; end
        OP_AREA_BR: begin res.word_kind = WK_SETTING; env_area_br = w[18:0]; end
        OP_OFFSET:  begin res.word_kind = WK_SETTING; env_offset  = w[21:0]; end
        OP_MASK:    begin res.word_kind = WK_SETTING; env_mask    = w[1:0]; end
        OP_IRQ: begin
          res.word_kind = WK_SETTING;
          if (!irq_flag) begin
            irq_flag      = 1'b1;
            res.irq_raise = 1'b1;
          end
        end
        OP_FILL: begin
          res.word_kind = WK_HEADER; res.packet_type = PK_FILL;
          start_packet(PK_FILL, 4'd2);
        end
        OP_COPY: begin
          res.word_kind = WK_HEADER; res.packet_type = PK_COPY;
          start_packet(PK_COPY, 4'd3);
        end
        OP_TOVRAM: begin
          res.word_kind = WK_HEADER; res.packet_type = PK_TOVRAM;
          start_packet(PK_TOVRAM, 4'd2);
        end
        OP_FROMVRAM: begin
          res.word_kind = WK_HEADER; res.packet_type = PK_FROMVRAM;
          start_packet(PK_FROMVRAM, 4'd2);
        end
        OP_NOP_00, OP_NOP_01, OP_NOP_03, OP_NOP_04,
        OP_NOP_1E, OP_NOP_E0, OP_NOP_E7, OP_NOP_EF: res.word_kind = WK_NOP;
        default: begin
          res.word_kind = WK_HEADER;
          case (w[31:29])
            PRIM_POLY: begin
              nv = (3 + b27) * (1 + tex + shade) - shade;
              res.packet_type = PK_POLYGON;
              start_packet(PK_POLYGON, nv[3:0]);
            end
            PRIM_LINE: begin
              if (b27) begin
                res.packet_type = PK_POLYLINE;
                open_pkt        = PK_POLYLINE;
                params_due      = '0;
                rx_mode         = MODE_POLY;
              end else begin
                res.packet_type = PK_LINE;
                start_packet(PK_LINE, shade ? 4'd3 : 4'd2);
              end
            end
            PRIM_RECT: begin
              res.packet_type = PK_RECT;
              start_packet(PK_RECT, 4'd1 + {3'd0, w[28:27] == 2'd0} + {3'd0, tex});
            end
            default: res.word_kind = WK_INVALID;
          endcase
        end
      endcase
    end
    res.params_left = params_due;
    res.pixels_left = pixels_due;
    res.read_data   = read_latch;
    res.irq         = irq_flag;
    res.draw_mode   = env_draw;
    res.mask_bits   = env_mask;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 30) $display("ERROR t=%0t result %0d: %s", $time, n_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (framed_q.size() == 0) begin
        report_mismatch("result word with no input word pending");
      end else begin
        want = framed_q.pop_front();
        check_field("word_kind", out_data_o.word_kind, want.word_kind);
        check_field("packet_type", out_data_o.packet_type, want.packet_type);
        check_field("last", out_data_o.last, want.last);
        check_field("params_left", out_data_o.params_left, want.params_left);
        check_field("pixels_left", out_data_o.pixels_left, want.pixels_left);
        check_field("read_data", out_data_o.read_data, want.read_data);
        check_field("irq", out_data_o.irq, want.irq);
        check_field("irq_raise", out_data_o.irq_raise, want.irq_raise);
        check_field("draw_mode", out_data_o.draw_mode, want.draw_mode);
        check_field("mask_bits", out_data_o.mask_bits, want.mask_bits);
        if (want.last) n_closed++;
        if (want.word_kind == WK_IMAGE) n_image++;
      end
      n_checked++;
    end
  end

  // receiver: long hold-offs on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_cnt < hold_req) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TIMEOUT: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic port, input logic [31:0] w);
    in_word_t item;
    item.port      = port;
    item.data_word = w;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    framed_q.push_back(frame_word(item));
    n_sent++;
    if (port) n_ctl++;
  endtask

  function automatic logic [31:0] rand_control();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0:       w[31:24] = CTL_RESET;
      1, 2:    w[31:24] = CTL_CLRBUF;
      3, 4:    w[31:24] = CTL_IRQ_ACK;
      5, 6, 7: w[31:24] = CTL_INFO;
      default: ;
    endcase
    return w;
  endfunction

  // follow the open packet to its end; now and then break in with a control word
  task automatic feed_packet();
    logic [31:0] w;
    while (rx_mode != MODE_CMD) begin
      w = $urandom();
      if ($urandom_range(0, 29) == 0) begin
        send_word(1'b1, rand_control());
      end else begin
        if (rx_mode == MODE_POLY && $urandom_range(0, 3) == 0) w = w | TERM_PATTERN;
        // keep images short: small width and height, upper bits random
        if (rx_mode == MODE_PARAMS && open_pkt == PK_TOVRAM && params_due == 4'd1) begin
          w[9:0]   = 10'($urandom_range(1, 12));
          w[24:16] = 9'($urandom_range(1, 6));
        end
        send_word(1'b0, w);
      end
    end
  endtask

  task automatic test_directed_words();
    send_word(1'b1, {CTL_INFO, 24'h000002});
    send_word(1'b0, {OP_DRAWMODE, 24'hFFFFFF});
    send_word(1'b0, {OP_TEXWIN, 24'hFFFFFF});
    send_word(1'b0, {OP_AREA_TL, 24'hFFFFFF});
    send_word(1'b0, {OP_AREA_BR, 24'hFFFFFF});
    send_word(1'b0, {OP_OFFSET, 24'hFFFFFF});
    send_word(1'b0, {OP_MASK, 24'hFFFFFF});
    send_word(1'b1, {CTL_INFO, 21'h1FFFFF, INFO_TEXWIN});
    send_word(1'b1, {CTL_INFO, 21'h1FFFFF, INFO_AREA_TL});
    send_word(1'b1, {CTL_INFO, 21'h1FFFFF, INFO_AREA_BR});
    send_word(1'b1, {CTL_INFO, 21'h1FFFFF, INFO_OFFSET});
    send_word(1'b1, {CTL_INFO, 24'h000007});
    send_word(1'b0, {OP_IRQ, 24'h000000});
    send_word(1'b0, {OP_IRQ, 24'hFFFFFF});
    send_word(1'b1, {CTL_IRQ_ACK, 24'h000000});
    send_word(1'b0, {OP_NOP_EF, 24'hFFFFFF});
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'h0500_0000);
    // polyline closed by the terminator pattern
    send_word(1'b0, 32'h4800_0000);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, TERM_PATTERN);
    // one-pixel image: a single word consumes one pixel
    send_word(1'b0, {OP_TOVRAM, 24'h000000});
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, 32'h0001_0001);
    send_word(1'b0, 32'hFFFF_FFFF);
    // zero size wraps to the largest image; drop it with a buffer clear
    send_word(1'b0, {OP_TOVRAM, 24'hFFFFFF});
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, 32'h1234_5678);
    send_word(1'b1, {CTL_CLRBUF, 24'h000000});
    send_word(1'b1, {CTL_RESET, 24'h000000});
    send_word(1'b1, {CTL_INFO, 24'h000005});
    send_word(1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int n_words);
    int          stop_at;
    logic [31:0] w;
    stop_at = n_sent + n_words;
    while (n_sent < stop_at) begin
      w = $urandom();
      case ($urandom_range(0, 11))
        0, 1:  w[31:29] = PRIM_POLY;
        2, 3:  w[31:29] = PRIM_LINE;
        4:     w[31:29] = PRIM_RECT;
        5: begin
          case ($urandom_range(0, 3))
            0:       w[31:24] = OP_FILL;
            1:       w[31:24] = OP_COPY;
            2:       w[31:24] = OP_TOVRAM;
            default: w[31:24] = OP_FROMVRAM;
          endcase
        end
        6, 7: begin
          case ($urandom_range(0, 6))
            0:       w[31:24] = OP_DRAWMODE;
            1:       w[31:24] = OP_TEXWIN;
            2:       w[31:24] = OP_AREA_TL;
            3:       w[31:24] = OP_AREA_BR;
            4:       w[31:24] = OP_OFFSET;
            5:       w[31:24] = OP_MASK;
            default: w[31:24] = OP_IRQ;
          endcase
        end
        8: begin
          case ($urandom_range(0, 7))
            0:       w[31:24] = OP_NOP_00;
            1:       w[31:24] = OP_NOP_01;
            2:       w[31:24] = OP_NOP_03;
            3:       w[31:24] = OP_NOP_04;
            4:       w[31:24] = OP_NOP_1E;
            5:       w[31:24] = OP_NOP_E0;
            6:       w[31:24] = OP_NOP_E7;
            default: w[31:24] = OP_NOP_EF;
          endcase
        end
        9:       ;
        default: w = rand_control();
      endcase
      send_word(($urandom_range(0, 11) >= 10) ? 1'b1 : 1'b0, w);
      feed_packet();
    end
  endtask

  task automatic test_output_holdoff();
    idle_en  = 1'b0;
    hold_req = hold_req + 80;
    // fill packets back to back while the receiver holds off
    repeat (8) begin
      send_word(1'b0, {OP_FILL, 24'($urandom())});
      feed_packet();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    test_random_traffic(15);
    // drop valid so the last word is not taken twice while draining
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    test_random_traffic(15);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    test_directed_words();
    test_random_traffic(200);
    idle_en = 1'b0;
    test_random_traffic(60);
    idle_en = 1'b1;
    test_random_traffic(150);
    test_output_holdoff();
    test_drain_pause();
    idle_en = 1'b0;
    test_random_traffic(60);
    in_valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Sent %0d words (%0d control), checked %0d results.", n_sent, n_ctl, n_checked);
    $display("Closed %0d packets, %0d image words, %0d mismatches.",
             n_closed, n_image, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
